@@ src/srts_pkg.sv @@
package srts_pkg;

	// Image sector size is 2048 bytes, so scaling is a shift by 11 - disk_sector_shift.
	localparam int unsigned ImageShift = 11;
	localparam int unsigned ShiftMin = 9;
	localparam int unsigned ShiftMax = 12;
	localparam int unsigned LengthMax = 64;
	localparam int unsigned ResultLimit = 64;

	// Command codes.
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	// Configuration register indexes.
	localparam logic REG_CHUNK_COUNT = 1'b0;
	localparam logic REG_DISK_SHIFT  = 1'b1;

	// One chunk table entry as stored in the table memory.
	typedef struct packed {
		logic [31:0] image_first;
		logic [31:0] image_last;
		logic [63:0] disk_first;
	} chunk_t;

	// One queued input beat.
	typedef struct packed {
		cmd_t        command;
		logic [7:0]  entry_index;
		chunk_t      chunk;
		logic [31:0] request_sector;
		logic [6:0]  request_length;
		logic [31:0] buffer_address;
	} item_t;

endpackage

@@ src/srts_ram.sv @@
module srts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/srts_front.sv @@
module srts_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  srts_pkg::item_t item_in,
	output logic           item_valid,
	output srts_pkg::item_t item_out,
	input  logic           item_pop
);
	import srts_pkg::*;

	item_t      queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy;
	assign item_valid = (count_q != 2'd0);
	assign item_out   = queue_q[rd_ptr_q];

	// Two-entry queue between the accepting side and the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, item_pop};
		end
	end

	// Payload storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item_in;
		end
	end
endmodule

@@ src/srts_back.sv @@
module srts_back #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_TRANSFER = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  srts_pkg::item_t item,
	output logic            item_pop,
	input  logic [8:0]      chunk_count,
	input  logic [1:0]      shift_code,
	output logic            tbl_we,
	output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] tbl_waddr,
	output srts_pkg::chunk_t tbl_wdata,
	output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] tbl_raddr,
	input  srts_pkg::chunk_t tbl_rdata,
	output logic            result_strobe,
	output logic [63:0]     disk_sector,
	output logic [6:0]      transfer_length,
	output logic [31:0]     transfer_address,
	output logic            final_transfer
);
	import srts_pkg::*;

	localparam int IW = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW0 = $clog2(TABLE_ENTRIES + 1);
	localparam int LW = CW0 > 9 ? CW0 : 9;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RUN, ST_RCMP, ST_SCAN, ST_MAP, ST_SPLIT, ST_FINISH
	} state_t;

	state_t       state_q;
	logic [32:0]  sec_q;
	logic [6:0]   left_q;
	logic [31:0]  addr_q;
	logic [31:0]  phys_q;
	logic [63:0]  dsec_q;
	logic [8:0]   tmp_q;
	logic [1:0]   sh_q;
	logic [6:0]   count_q;
	logic [IW-1:0] recent_q;
	logic         recent_valid_q;
	logic [LW-1:0] issue_q;
	logic         pend_q;
	logic [IW-1:0] pend_idx_q;
	chunk_t       ent_q;
	logic         hit_q;
	logic         held_q;
	logic [63:0]  held_dsec_q;
	logic [6:0]   held_len_q;
	logic [31:0]  held_addr_q;

	logic [LW-1:0] lim;
	logic          covers;
	logic [32:0]   room;
	logic [6:0]    run;
	logic [32:0]   diff;
	logic [34:0]   offset;
	logic [8:0]    run_scaled;
	logic [8:0]    len;
	logic [31:0]   step;
	logic [6:0]    left_init;

	// Scan limit is the loaded count, capped at the table size.
	assign lim = (LW'(chunk_count) >= LW'(TABLE_ENTRIES)) ? LW'(TABLE_ENTRIES) : LW'(chunk_count);

	// The current sector lies in the chunk at the table read port.
	assign covers = (sec_q >= {1'b0, tbl_rdata.image_first}) &&
		(sec_q <= {1'b0, tbl_rdata.image_last});

	// Run length, clipped at the chunk end when a chunk matched.
	assign room = {1'b0, ent_q.image_last} - sec_q + 33'd1;
	assign run  = (hit_q && (room < {26'd0, left_q})) ? room[6:0] : left_q;
	assign diff = sec_q - {1'b0, ent_q.image_first};

	// Scaling by 2048 >> shift for the four shift settings.
	always_comb begin
		case (sh_q)
			2'd0: begin
				offset     = {diff, 2'b00};
				run_scaled = {run, 2'b00};
			end
			2'd1: begin
				offset     = {1'b0, diff, 1'b0};
				run_scaled = {1'b0, run, 1'b0};
			end
			2'd2: begin
				offset     = {2'b00, diff};
				run_scaled = {2'b00, run};
			end
			default: begin
				offset     = {3'b000, diff[32:1]};
				run_scaled = {3'b000, run[6:1]};
			end
		endcase
	end

	assign len  = (tmp_q >= 9'(MAX_TRANSFER)) ? 9'(MAX_TRANSFER) : tmp_q;
	assign step = 32'(MAX_TRANSFER) << (ShiftMin + 32'(sh_q));
	assign left_init = (item.request_length > 7'(LengthMax)) ? 7'(LengthMax)
		: item.request_length;

	// Table write on a load, table reads for recent check and scan.
	assign item_pop  = (state_q == ST_IDLE) && item_valid;
	assign tbl_we    = item_pop && (item.command == CMD_LOAD) &&
		(32'(item.entry_index) < 32'(TABLE_ENTRIES));
	assign tbl_waddr = IW'(item.entry_index);
	assign tbl_wdata = item.chunk;
	assign tbl_raddr = (state_q == ST_RUN) ? recent_q : issue_q[IW-1:0];

	// Sequencer: run lookup, mapping and transfer split, with one held result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			recent_q       <= '0;
			recent_valid_q <= 1'b0;
			pend_q         <= 1'b0;
			held_q         <= 1'b0;
			result_strobe  <= 1'b0;
			count_q        <= '0;
			issue_q        <= '0;
		end else begin
			result_strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (item_pop && item.command == CMD_READ) begin
						sec_q   <= {1'b0, item.request_sector};
						left_q  <= left_init;
						addr_q  <= item.buffer_address;
						sh_q    <= shift_code;
						count_q <= '0;
						state_q <= (left_init == 7'd0) ? ST_FINISH : ST_RUN;
					end
				end
				ST_RUN: begin
					issue_q <= '0;
					pend_q  <= 1'b0;
					state_q <= recent_valid_q ? ST_RCMP : ST_SCAN;
				end
				ST_RCMP: begin
					if (covers) begin
						ent_q   <= tbl_rdata;
						hit_q   <= 1'b1;
						state_q <= ST_MAP;
					end else begin
						recent_valid_q <= 1'b0;
						state_q        <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pend_q && covers) begin
						ent_q          <= tbl_rdata;
						hit_q          <= 1'b1;
						recent_q       <= pend_idx_q;
						recent_valid_q <= 1'b1;
						state_q        <= ST_MAP;
					end else if (issue_q < lim) begin
						pend_q     <= 1'b1;
						pend_idx_q <= issue_q[IW-1:0];
						issue_q    <= issue_q + LW'(1);
					end else begin
						hit_q   <= 1'b0;
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					dsec_q  <= hit_q ? (ent_q.disk_first + {29'd0, offset}) : {31'd0, sec_q};
					tmp_q   <= run_scaled;
					phys_q  <= addr_q;
					sec_q   <= sec_q + {26'd0, run};
					left_q  <= left_q - run;
					addr_q  <= addr_q + {14'd0, run, 11'd0};
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					if (tmp_q != 9'd0) begin
						if (count_q < 7'(ResultLimit)) begin
							count_q          <= count_q + 7'd1;
							held_q           <= 1'b1;
							held_dsec_q      <= dsec_q;
							held_len_q       <= len[6:0];
							held_addr_q      <= phys_q;
							result_strobe    <= held_q;
							disk_sector      <= held_dsec_q;
							transfer_length  <= held_len_q;
							transfer_address <= held_addr_q;
							final_transfer   <= 1'b0;
						end
						tmp_q  <= tmp_q - len;
						dsec_q <= dsec_q + {55'd0, len};
						phys_q <= phys_q + step;
					end else begin
						state_q <= (left_q != 7'd0) ? ST_RUN : ST_FINISH;
					end
				end
				ST_FINISH: begin
					result_strobe    <= held_q;
					disk_sector      <= held_dsec_q;
					transfer_length  <= held_len_q;
					transfer_address <= held_addr_q;
					final_transfer   <= 1'b1;
					held_q           <= 1'b0;
					state_q          <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

@@ src/sector_remap_and_transfer_split.sv @@
// Splits image-sector read requests into disk transfers through a loaded chunk
// table. A beat is taken when start is high and busy is low; up to two beats
// wait in a queue while the sequencer works, and results come out one per
// cycle on result_strobe while a run is split, and cannot be held off. A table
// load is written by the sequencer in its idle state. A read goes, per run,
// through a lookup of the recent chunk when it matches, otherwise a scan of
// the table memory (one entry per cycle through its single read port), then a
// map step, a split step per transfer and one more; plus the idle and finish states.
module sector_remap_and_transfer_split #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_TRANSFER = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [7:0]  entry_index,
	input  logic [31:0] image_first,
	input  logic [31:0] image_last,
	input  logic [63:0] disk_first,
	input  logic [31:0] request_sector,
	input  logic [6:0]  request_length,
	input  logic [31:0] buffer_address,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        result_strobe,
	output logic [63:0] disk_sector,
	output logic [6:0]  transfer_length,
	output logic [31:0] transfer_address,
	output logic        final_transfer
);
	import srts_pkg::*;

	localparam int IW = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;

	logic [8:0] chunk_count_q;
	logic [3:0] disk_shift_q;
	logic [1:0] shift_code;
	item_t      item_in;
	item_t      item_q;
	logic       item_valid;
	logic       item_pop;
	logic       tbl_we;
	logic [IW-1:0] tbl_waddr;
	logic [IW-1:0] tbl_raddr;
	chunk_t     tbl_wdata;
	chunk_t     tbl_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q <= '0;
			disk_shift_q  <= 4'(ShiftMin);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CHUNK_COUNT: chunk_count_q <= cfg_data;
				default:         disk_shift_q  <= cfg_data[3:0];
			endcase
		end
	end

	// Shift saturated to the supported range, kept as an offset from the minimum.
	always_comb begin
		if (disk_shift_q < 4'(ShiftMin)) begin
			shift_code = 2'd0;
		end else if (disk_shift_q > 4'(ShiftMax)) begin
			shift_code = 2'(ShiftMax - ShiftMin);
		end else begin
			shift_code = 2'(disk_shift_q - 4'(ShiftMin));
		end
	end

	always_comb begin
		item_in.command           = cmd_t'(command);
		item_in.entry_index       = entry_index;
		item_in.chunk.image_first = image_first;
		item_in.chunk.image_last  = image_last;
		item_in.chunk.disk_first  = disk_first;
		item_in.request_sector    = request_sector;
		item_in.request_length    = request_length;
		item_in.buffer_address    = buffer_address;
	end

	srts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item_in   (item_in),
		.item_valid(item_valid),
		.item_out  (item_q),
		.item_pop  (item_pop)
	);

	srts_ram #(
		.WIDTH($bits(chunk_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	srts_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_TRANSFER (MAX_TRANSFER)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item            (item_q),
		.item_pop        (item_pop),
		.chunk_count     (chunk_count_q),
		.shift_code      (shift_code),
		.tbl_we          (tbl_we),
		.tbl_waddr       (tbl_waddr),
		.tbl_wdata       (tbl_wdata),
		.tbl_raddr       (tbl_raddr),
		.tbl_rdata       (tbl_rdata),
		.result_strobe   (result_strobe),
		.disk_sector     (disk_sector),
		.transfer_length (transfer_length),
		.transfer_address(transfer_address),
		.final_transfer  (final_transfer)
	);
endmodule
